// File: design/trpmd_pkg.sv
// Shared types and constants for the touch report press/move detector.
// No dependencies; compile first.
package trpmd_pkg;

    localparam int unsigned TYPE_W  = 16;
    localparam int unsigned CODE_W  = 16;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 16;

    localparam logic OP_EVENT     = 1'b0;
    localparam logic OP_BATCH_END = 1'b1;

    localparam logic [TYPE_W-1:0] TYPE_SYNC = 16'd0;
    localparam logic [TYPE_W-1:0] TYPE_KEY  = 16'd1;
    localparam logic [TYPE_W-1:0] TYPE_ABS  = 16'd3;

    localparam logic [CODE_W-1:0] CODE_SYNC_REPORT = 16'd0;
    localparam logic [CODE_W-1:0] CODE_ABS_X       = 16'd53;
    localparam logic [CODE_W-1:0] CODE_ABS_Y       = 16'd54;
    localparam logic [CODE_W-1:0] CODE_ABS_ID      = 16'd57;
    localparam logic [CODE_W-1:0] CODE_KEY_TOUCH   = 16'd330;

    localparam logic signed [VALUE_W-1:0] KEY_PRESSED = 32'sd1;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_MOVE    = 2'd2
    } t_kind;

    typedef struct packed {
        logic                      op;
        logic [TYPE_W-1:0]         ev_type;
        logic [CODE_W-1:0]         ev_code;
        logic signed [VALUE_W-1:0] ev_value;
    } t_evt;

    typedef struct packed {
        t_kind            kind;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             last;
    } t_rpt;

    typedef struct packed {
        logic [1:0] cnt;
        t_rpt       ent0;
        t_rpt       ent1;
    } t_push;

endpackage

// File: design/trpmd_if.sv
// Channel interfaces: event words in, press/release/move reports out.
// Depends on trpmd_pkg.
interface trpmd_evt_if;
    import trpmd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [TYPE_W-1:0]         ev_type;
    logic [CODE_W-1:0]         ev_code;
    logic signed [VALUE_W-1:0] ev_value;

    modport source (output valid, output op, output ev_type, output ev_code,
                    output ev_value, input ready);
    modport sink (input valid, input op, input ev_type, input ev_code,
                  input ev_value, output ready);
endinterface

interface trpmd_rpt_if;
    import trpmd_pkg::*;

    logic             valid;
    logic             ready;
    t_kind            kind;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             last;

    modport source (output valid, output kind, output pos_x, output pos_y,
                    output last, input ready);
    modport sink (input valid, input kind, input pos_x, input pos_y,
                  input last, output ready);
endinterface

// File: design/trpmd_queue.sv
// Result queue: takes up to two reports per cycle, one out per ready cycle.
// Depends on trpmd_pkg and trpmd_rpt_if.
module trpmd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  trpmd_pkg::t_push i_push,
    output logic             o_room,
    trpmd_rpt_if.source      o_rpt
);
    import trpmd_pkg::*;

    t_rpt              r_ent [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_cnt;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_cnt;
    logic [QPTR_W-1:0] w_wr_ptr1;
    logic              w_pop;
    t_rpt              w_head;

    assign w_pop     = o_rpt.valid && o_rpt.ready;
    assign w_wr_ptr1 = r_wr_ptr + QPTR_W'(1);
    assign o_room    = (r_cnt <= QCNT_W'(QUEUE_DEPTH - 2));

    always_comb begin
        n_wr_ptr = r_wr_ptr + QPTR_W'(i_push.cnt);
        n_rd_ptr = r_rd_ptr + QPTR_W'(w_pop);
        n_cnt    = r_cnt + QCNT_W'(i_push.cnt) - QCNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_ent[r_wr_ptr] <= i_push.ent0;
        end
        if (i_push.cnt == 2'd2) begin
            r_ent[w_wr_ptr1] <= i_push.ent1;
        end
    end

    assign w_head      = r_ent[r_rd_ptr];
    assign o_rpt.valid = (r_cnt != '0);
    assign o_rpt.kind  = w_head.kind;
    assign o_rpt.pos_x = w_head.pos_x;
    assign o_rpt.pos_y = w_head.pos_y;
    assign o_rpt.last  = w_head.last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> o_room)
        else $error("push without room");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with pointers apart");

endmodule

// File: design/touch_report_press_move_detector.sv
// Top level: latches touch event words, folds sync reports into one finger
// record, reports press/release/move at batch ends. Depends on trpmd_pkg,
// trpmd_if and trpmd_queue.
//
//  port    dir  transaction            payload
//  i_evt   in   one event word         op, ev_type, ev_code, ev_value
//  o_rpt   out  one finger report      kind, pos_x, pos_y, last
//
// One event word is taken every cycle while i_evt.ready is high. A word waits
// in the input register, then updates state and pushes its reports into a
// four-entry queue. A batch end gives up to two reports, drained one per cycle
// while o_rpt.ready is high. Reset is synchronous, active low, and clears all
// state but the input word and queue entries. i_evt.ready drops while the input
// register is held because the queue has fewer than two free entries.
module touch_report_press_move_detector #(
    parameter int unsigned COORD_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    trpmd_evt_if.sink    i_evt,
    trpmd_rpt_if.source  o_rpt
);
    import trpmd_pkg::*;

    localparam logic [VALUE_W:0] C_MAX = (33'd1 << COORD_BITS) - 33'd1;

    typedef logic [COORD_BITS-1:0] t_coord;

    function automatic t_coord f_sat(logic signed [VALUE_W-1:0] v);
        if (v[VALUE_W-1]) begin
            return '0;
        end
        if ({1'b0, v} > C_MAX) begin
            return C_MAX[COORD_BITS-1:0];
        end
        return v[COORD_BITS-1:0];
    endfunction

    function automatic logic [POS_W-1:0] f_pos(t_coord c);
        logic [31:0] w;
        w = 32'(c);
        return w[POS_W-1:0];
    endfunction

    t_evt   r_in;
    logic   r_in_vld;
    t_coord r_lat_x;
    t_coord r_lat_y;
    logic   r_lat_id_ok;
    logic   r_lat_down;
    logic   r_fin_act;
    t_coord r_fin_x;
    t_coord r_fin_y;
    logic   r_snap_act;
    t_coord r_snap_x;
    t_coord r_snap_y;

    t_coord n_lat_x;
    t_coord n_lat_y;
    logic   n_lat_id_ok;
    logic   n_lat_down;
    logic   n_fin_act;
    t_coord n_fin_x;
    t_coord n_fin_y;
    logic   n_snap_act;
    t_coord n_snap_x;
    t_coord n_snap_y;

    logic   w_room;
    logic   w_proc;
    logic   w_press;
    logic   w_release;
    logic   w_move;
    t_push  w_push;

    assign w_proc      = r_in_vld && w_room;
    assign i_evt.ready = !r_in_vld || w_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_evt.ready) begin
            r_in_vld <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_in.op       <= i_evt.op;
            r_in.ev_type  <= i_evt.ev_type;
            r_in.ev_code  <= i_evt.ev_code;
            r_in.ev_value <= i_evt.ev_value;
        end
    end

    assign w_press   = !r_snap_act && r_fin_act;
    assign w_release = r_snap_act && !r_fin_act;
    assign w_move    = r_fin_act && ((r_fin_x != r_snap_x) || (r_fin_y != r_snap_y));

    always_comb begin
        n_lat_x     = r_lat_x;
        n_lat_y     = r_lat_y;
        n_lat_id_ok = r_lat_id_ok;
        n_lat_down  = r_lat_down;
        n_fin_act   = r_fin_act;
        n_fin_x     = r_fin_x;
        n_fin_y     = r_fin_y;
        n_snap_act  = r_snap_act;
        n_snap_x    = r_snap_x;
        n_snap_y    = r_snap_y;

        w_push.cnt        = 2'd0;
        w_push.ent0.kind  = KIND_MOVE;
        w_push.ent0.pos_x = f_pos(r_fin_x);
        w_push.ent0.pos_y = f_pos(r_fin_y);
        w_push.ent0.last  = 1'b1;
        w_push.ent1.kind  = KIND_MOVE;
        w_push.ent1.pos_x = f_pos(r_fin_x);
        w_push.ent1.pos_y = f_pos(r_fin_y);
        w_push.ent1.last  = 1'b1;

        if (w_proc) begin
            if (r_in.op == OP_EVENT) begin
                if (r_in.ev_type == TYPE_ABS) begin
                    if (r_in.ev_code == CODE_ABS_X) begin
                        n_lat_x = f_sat(r_in.ev_value);
                    end else if (r_in.ev_code == CODE_ABS_Y) begin
                        n_lat_y = f_sat(r_in.ev_value);
                    end else if (r_in.ev_code == CODE_ABS_ID) begin
                        n_lat_id_ok = !r_in.ev_value[VALUE_W-1];
                    end
                end else if (r_in.ev_type == TYPE_KEY) begin
                    if (r_in.ev_code == CODE_KEY_TOUCH) begin
                        n_lat_down = (r_in.ev_value == KEY_PRESSED);
                    end
                end else if (r_in.ev_type == TYPE_SYNC &&
                             r_in.ev_code == CODE_SYNC_REPORT) begin
                    n_fin_act = r_lat_down && r_lat_id_ok;
                    if (r_lat_x != '0 || r_lat_y != '0) begin
                        n_fin_x = r_lat_x;
                        n_fin_y = r_lat_y;
                    end
                end
            end else begin
                if (w_press) begin
                    w_push.ent0.kind = KIND_PRESS;
                    w_push.ent0.last = !w_move;
                    w_push.cnt       = w_move ? 2'd2 : 2'd1;
                end else if (w_release) begin
                    w_push.ent0.kind = KIND_RELEASE;
                    w_push.cnt       = 2'd1;
                end else if (w_move) begin
                    w_push.cnt = 2'd1;
                end
                n_snap_act = r_fin_act;
                n_snap_x   = r_fin_x;
                n_snap_y   = r_fin_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lat_x     <= '0;
            r_lat_y     <= '0;
            r_lat_id_ok <= 1'b1;
            r_lat_down  <= 1'b0;
            r_fin_act   <= 1'b0;
            r_fin_x     <= '0;
            r_fin_y     <= '0;
            r_snap_act  <= 1'b0;
            r_snap_x    <= '0;
            r_snap_y    <= '0;
        end else begin
            r_lat_x     <= n_lat_x;
            r_lat_y     <= n_lat_y;
            r_lat_id_ok <= n_lat_id_ok;
            r_lat_down  <= n_lat_down;
            r_fin_act   <= n_fin_act;
            r_fin_x     <= n_fin_x;
            r_fin_y     <= n_fin_y;
            r_snap_act  <= n_snap_act;
            r_snap_x    <= n_snap_x;
            r_snap_y    <= n_snap_y;
        end
    end

    trpmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_rpt   (o_rpt)
    );

    a_event_no_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_in.op == OP_EVENT) |-> (w_push.cnt == 2'd0))
        else $error("event word produced a report");

    a_release_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_in.op == OP_BATCH_END && w_release) |-> (w_push.cnt == 2'd1))
        else $error("release paired with another report");

    a_snap_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_in.op == OP_BATCH_END) |=>
            (r_snap_act == $past(r_fin_act) && r_snap_x == $past(r_fin_x) &&
             r_snap_y == $past(r_fin_y)))
        else $error("snapshot not taken at batch end");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_room) |=> (r_in_vld && $stable(r_in)))
        else $error("stalled input register lost its item");

endmodule
